// ----- src/decimal_string_to_uint64_top_assert.svh -----
// Assertion macros used by the decimal string converter parse module.
`ifndef DECIMAL_STRING_TO_UINT64_TOP_ASSERT_SVH
`define DECIMAL_STRING_TO_UINT64_TOP_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define DSU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsu assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define DSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsu assertion failed");

`endif

// ----- src/dsu_pkg.sv -----
// Package: widths, character codes, limits and payload types of the decimal converter.
package dsu_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 5;
   localparam int DIGIT_W = 4;

   localparam logic [COUNT_W-1:0] MAX_DIGITS       = 5'd20;
   localparam logic [COUNT_W-1:0] LAST_DIGIT_SLOT  = 5'd19;
   localparam logic [VALUE_W-1:0] LIMIT_PREFIX     = 64'd1844674407370955161;
   localparam logic [DIGIT_W-1:0] LIMIT_LAST_DIGIT = 4'd5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
      logic              empty_string;
   } item_type;

   typedef struct packed {
      logic               is_valid;
      logic [VALUE_W-1:0] parsed_value;
   } result_type;

endpackage

// ----- src/dsu_req_if.sv -----
// Interface: input character channel with valid/ready handshake.
interface dsu_req_if;
   logic                        valid;
   logic                        ready;
   logic [dsu_pkg::CHAR_W-1:0]  character;
   logic                        last_char;
   logic                        empty_string;

   modport source (output valid, character, last_char, empty_string, input ready);
   modport sink   (input valid, character, last_char, empty_string, output ready);
endinterface

// ----- src/dsu_rsp_if.sv -----
// Interface: result channel with valid/ready handshake.
interface dsu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         is_valid;
   logic [dsu_pkg::VALUE_W-1:0]  parsed_value;

   modport source (output valid, is_valid, parsed_value, input ready);
   modport sink   (input valid, is_valid, parsed_value, output ready);
endinterface

// ----- src/dsu_parse.sv -----
// Parse state and per-character update: running value, digit count and failure flag.
module dsu_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  dsu_pkg::item_type   item,
   output logic                closes,
   output dsu_pkg::result_type result
);

   `include "decimal_string_to_uint64_top_assert.svh"

   logic [dsu_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic [dsu_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        at_start_ff, at_start_in;
   logic                        failed_ff, failed_in;

   logic [dsu_pkg::VALUE_W-1:0] acc_next;
   logic [dsu_pkg::COUNT_W-1:0] count_next;
   logic                        failed_next;
   logic [dsu_pkg::DIGIT_W-1:0] digit;
   logic                        is_digit;
   logic                        skip_plus;
   logic                        overflow;
   logic                        reject;
   logic                        take;
   logic                        ok;

   // Classify the character
   assign is_digit  = (item.character >= dsu_pkg::CHAR_ZERO) &&
                      (item.character <= dsu_pkg::CHAR_NINE);
   assign digit     = item.character[dsu_pkg::DIGIT_W-1:0];
   assign skip_plus = at_start_ff && (item.character == dsu_pkg::CHAR_PLUS);

   // Check the twentieth digit against the 64-bit limit
   assign overflow = (count_ff == dsu_pkg::LAST_DIGIT_SLOT) &&
                     ((acc_ff > dsu_pkg::LIMIT_PREFIX) ||
                      ((acc_ff == dsu_pkg::LIMIT_PREFIX) &&
                       (digit > dsu_pkg::LIMIT_LAST_DIGIT)));
   assign reject = !is_digit || (count_ff >= dsu_pkg::MAX_DIGITS) || overflow;
   assign take   = !failed_ff && !skip_plus && !reject;

   // Multiply by ten with shifts and add the new digit
   assign acc_next    = take ? ((acc_ff << 3) + (acc_ff << 1) +
                                dsu_pkg::VALUE_W'(digit)) : acc_ff;
   assign count_next  = take ? (count_ff + dsu_pkg::COUNT_W'(1)) : count_ff;
   assign failed_next = failed_ff || (!skip_plus && reject);

   // Form the result of a closing item
   assign closes = item.empty_string || item.last_char;
   assign ok     = !item.empty_string && !failed_next &&
                   (count_next != dsu_pkg::COUNT_W'(0));
   assign result.is_valid     = ok;
   assign result.parsed_value = ok ? acc_next : dsu_pkg::VALUE_W'(0);

   // Advance or clear the string state
   always_comb begin
      acc_in      = acc_ff;
      count_in    = count_ff;
      at_start_in = at_start_ff;
      failed_in   = failed_ff;
      if (step) begin
         if (closes) begin
            acc_in      = '0;
            count_in    = '0;
            at_start_in = 1'b1;
            failed_in   = 1'b0;
         end else begin
            acc_in      = acc_next;
            count_in    = count_next;
            at_start_in = 1'b0;
            failed_in   = failed_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         count_ff    <= '0;
         at_start_ff <= 1'b1;
         failed_ff   <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         count_ff    <= count_in;
         at_start_ff <= at_start_in;
         failed_ff   <= failed_in;
      end
   end

   `DSU_ASSERT_NEXT(a_close_clears, clock, reset, step && closes,
                    at_start_ff && !failed_ff && (count_ff == '0) && (acc_ff == '0))
   `DSU_ASSERT_NEXT(a_count_saturates, clock, reset,
                    step && !closes && (count_ff == dsu_pkg::MAX_DIGITS),
                    (count_ff == dsu_pkg::MAX_DIGITS) && $stable(acc_ff))
   `DSU_ASSERT_SAME(a_failed_never_valid, clock, reset, failed_ff, !result.is_valid)

endmodule

// ----- src/decimal_string_to_uint64_top.sv -----
// Path: a closing character is held in the input register, then its result is loaded into
// the result register and offered there; the multiply-by-ten-and-add of the running value
// and the 20th-digit limit compare are combinational between the two registers.
// Rate: one character per cycle while no closing character waits.
// A closing character waits only while an untransferred result holds the result register.
// Reset (synchronous, active high) empties both registers and returns the parse state
// to the start of a string; any partly received string is dropped.
module decimal_string_to_uint64_top (
   input  logic      clock,
   input  logic      reset,
   dsu_req_if.sink   req_if,
   dsu_rsp_if.source rsp_if
);

   logic                in_valid_ff;
   dsu_pkg::item_type   in_item_ff;
   logic                rsp_valid_ff;
   dsu_pkg::result_type rsp_result_ff;

   logic                closes;
   logic                out_free;
   logic                step;
   dsu_pkg::result_type result;

   // Advance the input register when it is empty or its item moves on
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && (!closes || out_free);
   assign req_if.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   // Hold the payload of the accepted transfer
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_item_ff.character    <= req_if.character;
         in_item_ff.last_char    <= req_if.last_char;
         in_item_ff.empty_string <= req_if.empty_string;
      end
   end

   dsu_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .closes (closes),
      .result (result)
   );

   // Load the result register on a closing item, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && closes) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && closes) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.is_valid     = rsp_result_ff.is_valid;
   assign rsp_if.parsed_value = rsp_result_ff.parsed_value;

endmodule
